[hdl/assert_macros.svh]
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/kli_pkg.sv]
// Package: types and constants of the keyframe interpolator
`default_nettype none
package kli_pkg;
  localparam int MaxKeys = 64;
  localparam int IdxW = $clog2(MaxKeys);
  localparam int CntW = IdxW + 1;
  localparam int TimeW = 32;
  localparam int ValW = 32;
  localparam int FracW = 16;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic [0:0] REG_KEY_COUNT = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_T, ST_SCAN, ST_SEG, ST_DIV, ST_RD_A, ST_RD_B, ST_MUL,
    ST_ADD, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [TimeW-1:0] num;
    logic [TimeW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage
`default_nettype wire

[hdl/kli_ram.sv]
// Generic single-port-write RAM with registered read
`default_nettype none
module kli_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/kli_div.sv]
// Restoring divider: floor((num << 16) / den), one quotient bit per cycle
`default_nettype none
module kli_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire kli_pkg::div_req_t req,
  output kli_pkg::div_stat_t stat,
  output logic [kli_pkg::FracW:0] quot
);
  import kli_pkg::*;
  // num < den always, so the quotient fits in FracW bits
  logic [TimeW:0] rem;
  logic [TimeW-1:0] den;
  logic [4:0] cnt;
  logic busy;
  logic done;
  logic [TimeW+1:0] shl;
  logic [TimeW+1:0] diff;

  assign shl = {rem, 1'b0};
  assign diff = shl - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 5'(FracW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= {1'b0, req.num};
      den <= req.den;
      quot <= '0;
    end else if (busy) begin
      if (!diff[TimeW+1]) begin
        rem <= diff[TimeW:0];
        quot <= {quot[FracW-1:0], 1'b1};
      end else begin
        rem <= shl[TimeW:0];
        quot <= {quot[FracW-1:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule
`default_nettype wire

[hdl/keyframe_linear_interpolator.sv]
// Top level: keyframe table in RAM, segment scan, divider and blend
//
//  channel  dir  handshake         payload
//  in       in   in_valid/ready    kind key_index key_time key_x key_y key_z query_time
//  out      out  out_valid/ready   out_x out_y out_z
//  cfg      in   APB psel/penable  key_count at byte 0
//
// A load is written to the table as it is taken. Query: each key time from key 0 up to the
// segment end is read and compared, then the segment is set up, divided, and the result
// blended and registered. Single-key, past-end and zero-length queries skip the divider.
// Input is taken only in idle; a finished query waits in ST_OUT while the output register
// still holds an untaken word, so no loads or queries are taken meanwhile.
// Reset (rst, synchronous) sets key_count to 1; the table contents stay undefined.
`default_nettype none
`include "assert_macros.svh"
module keyframe_linear_interpolator (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic kind,
  input  wire logic [5:0] key_index,
  input  wire logic [31:0] key_time,
  input  wire logic signed [31:0] key_x,
  input  wire logic signed [31:0] key_y,
  input  wire logic signed [31:0] key_z,
  input  wire logic [31:0] query_time,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import kli_pkg::*;

  state_t state, state_next;
  logic [6:0] key_count;
  logic [CntW-1:0] n_eff;
  logic [TimeW-1:0] q;
  logic [IdxW-1:0] idx;
  logic [TimeW-1:0] t0;
  logic [3*ValW-1:0] va;
  logic [FracW:0] factor;
  logic signed [65:0] prod [3];
  logic [3*ValW-1:0] res;
  logic [3*ValW-1:0] ovec;
  logic out_full;
  logic direct;   // result is simply va

  logic we;
  logic [IdxW-1:0] raddr;
  logic [TimeW-1:0] t_rd;
  logic [3*ValW-1:0] v_rd;
  div_req_t dreq;
  div_stat_t dstat;
  logic [FracW:0] dq;

  logic in_acc;
  logic cfg_wr;
  assign in_acc = in_valid && in_ready;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_KEY_COUNT);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KEY_COUNT) ? {25'd0, key_count} : 32'd0;
  assign we = in_acc && (kind == KIND_LOAD);

  always_comb begin
    if (key_count == 7'd0) n_eff = CntW'(1);
    else if (key_count > 7'(MaxKeys)) n_eff = CntW'(MaxKeys);
    else n_eff = CntW'(key_count);
  end

  kli_ram #(.Width(TimeW), .Depth(MaxKeys)) u_times (
    .clk(clk), .we(we), .waddr(key_index[IdxW-1:0]), .wdata(key_time),
    .raddr(raddr), .rdata(t_rd)
  );
  kli_ram #(.Width(3*ValW), .Depth(MaxKeys)) u_vals (
    .clk(clk), .we(we), .waddr(key_index[IdxW-1:0]), .wdata({key_x, key_y, key_z}),
    .raddr(raddr), .rdata(v_rd)
  );
  kli_div u_div (.clk(clk), .rst(rst), .req(dreq), .stat(dstat), .quot(dq));

  assign in_ready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc && kind == KIND_QUERY) state_next = ST_RD_T;
      ST_RD_T: state_next = ST_SCAN;
      ST_SCAN:
        if (n_eff == CntW'(1)) state_next = ST_RD_B;
        else if (idx == '0) state_next = ST_RD_T;
        else if (q < t_rd) state_next = ST_SEG;
        else if ({1'b0, idx} == n_eff - CntW'(1)) state_next = ST_RD_B;
        else state_next = ST_RD_T;
      ST_SEG:
        if (t_rd <= t0) state_next = ST_RD_B;
        else if (q <= t0) state_next = ST_RD_A;
        else state_next = ST_DIV;
      ST_DIV: if (dstat.done) state_next = ST_RD_A;
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = direct ? ST_OUT : ST_MUL;
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = ST_OUT;
      ST_OUT: state_next = out_full ? ST_OUT : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs to RAM and divider
  always_comb begin
    raddr = idx;
    dreq = '0;
    case (state)
      ST_RD_A: raddr = idx - IdxW'(1);
      ST_SEG: begin
        // flat or reversed segment reads the end value, else the start value
        raddr = (t_rd <= t0) ? idx : idx - IdxW'(1);
        dreq.start = !(t_rd <= t0) && (q > t0);
        dreq.num = q - t0;
        dreq.den = t_rd - t0;
      end
      default: raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      key_count <= 7'd1;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) key_count <= pwdata[6:0];
      if (state == ST_OUT && !out_full) out_full <= 1'b1;
      else if (out_valid && out_ready) out_full <= 1'b0;
    end
  end

  // datapath; idx tracks the candidate segment end key
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (in_acc) begin
        q <= query_time;
        direct <= 1'b1;
        idx <= '0;
        t0 <= '0;
      end
      ST_RD_T: ;
      ST_SCAN: if (n_eff == CntW'(1)) begin
        idx <= idx;
      end else if (idx == '0) begin
        // key 0 time is the first segment start
        t0 <= t_rd;
        idx <= IdxW'(1);
      end else if (!(q < t_rd)) begin
        if ({1'b0, idx} != n_eff - CntW'(1)) begin
          idx <= idx + IdxW'(1);
          t0 <= t_rd;
        end
      end else begin
        // t_rd is the end time; re-read it and the start time held in t0
        idx <= idx;
      end
      ST_SEG: begin
        // here t_rd still holds end time of the segment
        if (t_rd <= t0) direct <= 1'b1;
        else begin
          direct <= 1'b0;
          factor <= '0;
        end
      end
      ST_DIV: if (dstat.done) factor <= dq;
      ST_RD_A: ;
      ST_RD_B: va <= v_rd;
      ST_MUL: begin
        prod[0] <= 66'(($signed({v_rd[95], v_rd[95:64]}) - $signed({va[95], va[95:64]}))
                   * $signed({1'b0, factor}));
        prod[1] <= 66'(($signed({v_rd[63], v_rd[63:32]}) - $signed({va[63], va[63:32]}))
                   * $signed({1'b0, factor}));
        prod[2] <= 66'(($signed({v_rd[31], v_rd[31:0]}) - $signed({va[31], va[31:0]}))
                   * $signed({1'b0, factor}));
      end
      ST_ADD: begin
        res[95:64] <= va[95:64] + prod[0][47:16];
        res[63:32] <= va[63:32] + prod[1][47:16];
        res[31:0] <= va[31:0] + prod[2][47:16];
      end
      ST_OUT: if (!out_full) ovec <= direct ? va : res;
      default: ;
    endcase
  end

  // output register holds the word until taken
  assign out_valid = out_full;
  assign out_x = ovec[95:64];
  assign out_y = ovec[63:32];
  assign out_z = ovec[31:0];

  `ASSERT_IMPL(a_busy_idle, clk, rst, state == ST_IDLE, !dstat.busy)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPL(a_out_stall, clk, rst, state == ST_OUT && out_full, state_next == ST_OUT)
endmodule
`default_nettype wire
